// ===== rtl/core/wgba_pkg.sv =====
package wgba_pkg;

   localparam int BIN_COUNT = 4096;
   localparam int BIN_W     = $clog2(BIN_COUNT);

   localparam int CNT_W   = 16;
   localparam int AZS_W   = 32;
   localparam int WS_W    = 64;
   localparam int WG_W    = 48;
   localparam int ENTRY_W = CNT_W + AZS_W + 3 * WS_W + 3 * WG_W;

   localparam int DIV_N_W     = 7;
   localparam int SQRT_CNT_W  = 5;
   localparam int SQRT_STEPS  = 17;

   // request kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_SCAN   = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_NEWP   = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_VEL_FLOOR = 2'd0;
   localparam logic [1:0] CSR_PWR_FLOOR = 2'd1;
   localparam logic [1:0] CSR_WID_FLOOR = 2'd2;

   localparam logic [15:0] VEL_FLOOR_RST = 16'd100;
   localparam logic [15:0] PWR_FLOOR_RST = 16'd1;
   localparam logic [15:0] WID_FLOOR_RST = 16'd1;

   // datapath operations
   localparam logic [4:0] OP_NONE   = 5'd0;
   localparam logic [4:0] OP_LOAD   = 5'd1;
   localparam logic [4:0] OP_READ   = 5'd2;
   localparam logic [4:0] OP_LATCH  = 5'd3;
   localparam logic [4:0] OP_CLEAR  = 5'd4;
   localparam logic [4:0] OP_WDIV   = 5'd5;
   localparam logic [4:0] OP_MUL    = 5'd6;
   localparam logic [4:0] OP_ACC    = 5'd7;
   localparam logic [4:0] OP_WRITE  = 5'd8;
   localparam logic [4:0] OP_EVAL   = 5'd9;
   localparam logic [4:0] OP_AZDIV  = 5'd10;
   localparam logic [4:0] OP_AZTAKE = 5'd11;
   localparam logic [4:0] OP_MDIV   = 5'd12;
   localparam logic [4:0] OP_MTAKE  = 5'd13;
   localparam logic [4:0] OP_SDIV   = 5'd14;
   localparam logic [4:0] OP_SQRT   = 5'd15;
   localparam logic [4:0] OP_STAKE  = 5'd16;
   localparam logic [4:0] OP_FIRE   = 5'd17;

   typedef struct packed {
      logic [4:0]       op;
      logic [1:0]       lane;
      logic [BIN_W-1:0] addr;
   } ctl_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic full;
      logic valid;
   } sts_type;

endpackage

// ===== rtl/core/wgba_ram.sv =====
module wgba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/wgba_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// The dividend comes left aligned; steps gives how many of its bits count.
module wgba_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [63:0]                 num,
   input  logic [47:0]                 den,
   input  logic [wgba_pkg::DIV_N_W-1:0] steps,
   output logic [63:0]                 quo,
   output logic                        done
);

   logic [63:0] num_ff, num_in;
   logic [63:0] quo_ff, quo_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] den_ff, den_in;
   logic [wgba_pkg::DIV_N_W-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [48:0] trial;
   logic [48:0] diff;
   logic        ge;

   always_comb begin
      trial  = {rem_ff, num_ff[63]};
      diff   = trial - {1'b0, den_ff};
      ge     = trial >= {1'b0, den_ff};
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = num;
         den_in = den;
         quo_in = '0;
         rem_in = '0;
         cnt_in = steps;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         quo_in = {quo_ff[62:0], ge};
         rem_in = ge ? diff[47:0] : trial[47:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == wgba_pkg::DIV_N_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// ===== rtl/core/wgba_sqrt.sv =====
// Digit by digit integer square root of a 33 bit value, one step per cycle.
module wgba_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] x,
   output logic [16:0] root,
   output logic        done
);

   logic [32:0] x_ff, x_in;
   logic [33:0] r_ff, r_in;
   logic [33:0] bit_ff, bit_in;
   logic [wgba_pkg::SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [33:0] t;
   logic [33:0] rem;

   always_comb begin
      t       = r_ff + bit_ff;
      rem     = {1'b0, x_ff} - t;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         x_in   = x;
         r_in   = '0;
         bit_in = 34'h1_0000_0000;
         cnt_in = wgba_pkg::SQRT_CNT_W'(wgba_pkg::SQRT_STEPS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if ({1'b0, x_ff} >= t) begin
            x_in = rem[32:0];
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == wgba_pkg::SQRT_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign root = r_ff[16:0];
   assign done = done_ff;

endmodule

// ===== rtl/core/wgba_dp.sv =====
module wgba_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  wgba_pkg::ctl_type             ctl,
   output wgba_pkg::sts_type             sts,
   input  logic [1:0]                    req_kind,
   input  logic [wgba_pkg::BIN_W-1:0]    req_bin,
   input  logic signed [15:0]            req_velocity,
   input  logic [15:0]                   req_velocity_error,
   input  logic signed [15:0]            req_power,
   input  logic [15:0]                   req_power_error,
   input  logic signed [15:0]            req_width,
   input  logic [15:0]                   req_width_error,
   input  logic signed [11:0]            req_azimuth,
   input  logic [10:0]                   req_pixel_count,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [15:0]                   csr_wdata,
   output logic                          rsp_strobe,
   output logic [wgba_pkg::BIN_W-1:0]    rsp_out_bin,
   output logic                          rsp_valid_res,
   output logic signed [11:0]            rsp_mean_azimuth,
   output logic signed [15:0]            rsp_mean_velocity,
   output logic [15:0]                   rsp_velocity_sigma,
   output logic signed [15:0]            rsp_mean_power,
   output logic [15:0]                   rsp_power_sigma,
   output logic signed [15:0]            rsp_mean_width,
   output logic [15:0]                   rsp_width_sigma,
   output logic [15:0]                   rsp_sample_count
);

   localparam logic [63:0] DIV_UNIT = 64'h8000_0000_0000_0000;  // 2^32 left aligned

   // configuration
   logic [15:0] floor_ff [3];

   // request item
   logic [wgba_pkg::BIN_W-1:0] bin_ff;
   logic signed [15:0] val_ff [3];
   logic [15:0]        err_ff [3];
   logic signed [11:0] az_ff;
   logic [10:0]        npix_ff;
   logic [15:0]        scan_ff;

   // bin entry
   logic [wgba_pkg::CNT_W-1:0]        cnt_ff;
   logic signed [wgba_pkg::AZS_W-1:0] azs_ff;
   logic signed [wgba_pkg::WS_W-1:0]  ws_ff [3];
   logic [wgba_pkg::WG_W-1:0]         wg_ff [3];

   logic signed [50:0] prod_ff;
   logic [32:0]        w_ff;
   logic               sign_ff;
   logic               valid_ff;

   // results
   logic               strobe_ff;
   logic               ovalid_ff;
   logic signed [11:0] mean_az_ff;
   logic [15:0]        mean_ff [3];
   logic [15:0]        sigma_ff [3];

   // RAM
   logic                            ram_we;
   logic [wgba_pkg::BIN_W-1:0]      ram_waddr;
   logic [wgba_pkg::ENTRY_W-1:0]    ram_wdata;
   logic [wgba_pkg::ENTRY_W-1:0]    ram_rdata;

   // arithmetic units
   logic        div_start;
   logic [63:0] div_num;
   logic [47:0] div_den;
   logic [wgba_pkg::DIV_N_W-1:0] div_steps;
   logic [63:0] div_quo;
   logic        div_done;
   logic        sqrt_start;
   logic [16:0] sqrt_root;
   logic        sqrt_done;

   logic [15:0]        e_eff;
   logic [31:0]        e_sq;
   logic signed [16:0] mul_op;
   logic [31:0]        azs_mag;
   logic [63:0]        ws_mag;
   logic [26:0]        thr;
   logic [26:0]        cnt4;
   logic               valid_now;
   logic [15:0]        mean_sat;
   logic [31:0]        az_neg;
   logic [15:0]        q_neg;

   always_comb begin
      e_eff = (err_ff[ctl.lane] < floor_ff[ctl.lane]) ? floor_ff[ctl.lane] : err_ff[ctl.lane];
      if (e_eff == 16'd0) begin
         e_eff = 16'd1;
      end
      e_sq    = e_eff * e_eff;
      mul_op  = (ctl.lane == 2'd0) ? -{val_ff[0][15], val_ff[0]}
                                   : {val_ff[ctl.lane][15], val_ff[ctl.lane]};
      azs_mag = azs_ff[31] ? 32'(-azs_ff) : 32'(azs_ff);
      ws_mag  = ws_ff[ctl.lane][63] ? 64'(-ws_ff[ctl.lane]) : 64'(ws_ff[ctl.lane]);
      thr       = 27'(scan_ff * npix_ff);
      cnt4      = {9'd0, cnt_ff, 2'b00};
      valid_now = (cnt_ff != '0) && (cnt4 > thr);
      q_neg     = 16'd0 - div_quo[15:0];
      if (sign_ff) begin
         mean_sat = (div_quo > 64'd32768) ? 16'h8000 : q_neg;
      end else begin
         mean_sat = (div_quo > 64'd32767) ? 16'h7FFF : div_quo[15:0];
      end
      az_neg = 32'd0 - div_quo[31:0];
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      div_steps = '0;
      case (ctl.op)
         wgba_pkg::OP_WDIV: begin
            div_start = 1'b1;
            div_num   = DIV_UNIT;
            div_den   = {16'd0, e_sq};
            div_steps = wgba_pkg::DIV_N_W'(33);
         end
         wgba_pkg::OP_AZDIV: begin
            div_start = 1'b1;
            div_num   = {azs_mag, 32'd0};
            div_den   = {32'd0, cnt_ff};
            div_steps = wgba_pkg::DIV_N_W'(32);
         end
         wgba_pkg::OP_MDIV: begin
            div_start = 1'b1;
            div_num   = ws_mag;
            div_den   = wg_ff[ctl.lane];
            div_steps = wgba_pkg::DIV_N_W'(64);
         end
         wgba_pkg::OP_SDIV: begin
            div_start = 1'b1;
            div_num   = DIV_UNIT;
            div_den   = wg_ff[ctl.lane];
            div_steps = wgba_pkg::DIV_N_W'(33);
         end
         default: begin
         end
      endcase
   end

   assign sqrt_start = (ctl.op == wgba_pkg::OP_SQRT);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = bin_ff;
      ram_wdata = '0;
      case (ctl.op)
         wgba_pkg::OP_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = ctl.addr;
         end
         wgba_pkg::OP_EVAL: begin
            ram_we = 1'b1;
         end
         wgba_pkg::OP_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = {wg_ff[2], wg_ff[1], wg_ff[0], ws_ff[2], ws_ff[1], ws_ff[0],
                         32'(azs_ff + 32'(az_ff)), cnt_ff + 1'b1};
         end
         default: begin
         end
      endcase
   end

   wgba_ram #(
      .WIDTH (wgba_pkg::ENTRY_W),
      .DEPTH (wgba_pkg::BIN_COUNT)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ctl.op == wgba_pkg::OP_READ),
      .raddr (bin_ff),
      .rdata (ram_rdata)
   );

   wgba_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .quo   (div_quo),
      .done  (div_done)
   );

   wgba_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .x     (div_quo[32:0]),
      .root  (sqrt_root),
      .done  (sqrt_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff[0] <= wgba_pkg::VEL_FLOOR_RST;
         floor_ff[1] <= wgba_pkg::PWR_FLOOR_RST;
         floor_ff[2] <= wgba_pkg::WID_FLOOR_RST;
         scan_ff     <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               wgba_pkg::CSR_VEL_FLOOR: floor_ff[0] <= csr_wdata;
               wgba_pkg::CSR_PWR_FLOOR: floor_ff[1] <= csr_wdata;
               wgba_pkg::CSR_WID_FLOOR: floor_ff[2] <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (ctl.op == wgba_pkg::OP_LOAD) begin
            if (req_kind == wgba_pkg::KIND_SCAN && scan_ff != 16'hFFFF) begin
               scan_ff <= scan_ff + 1'b1;
            end else if (req_kind == wgba_pkg::KIND_NEWP) begin
               scan_ff <= '0;
            end
         end
         strobe_ff <= (ctl.op == wgba_pkg::OP_FIRE);
      end

      case (ctl.op)
         wgba_pkg::OP_LOAD: begin
            bin_ff    <= req_bin;
            val_ff[0] <= req_velocity;
            val_ff[1] <= req_power;
            val_ff[2] <= req_width;
            err_ff[0] <= req_velocity_error;
            err_ff[1] <= req_power_error;
            err_ff[2] <= req_width_error;
            az_ff     <= req_azimuth;
            npix_ff   <= req_pixel_count;
         end
         wgba_pkg::OP_LATCH: begin
            {wg_ff[2], wg_ff[1], wg_ff[0], ws_ff[2], ws_ff[1], ws_ff[0], azs_ff, cnt_ff}
               <= ram_rdata;
         end
         wgba_pkg::OP_MUL: begin
            prod_ff <= 51'(mul_op * $signed({1'b0, div_quo[32:0]}));
            w_ff    <= div_quo[32:0];
         end
         wgba_pkg::OP_ACC: begin
            ws_ff[ctl.lane] <= ws_ff[ctl.lane] + 64'(prod_ff);
            wg_ff[ctl.lane] <= wg_ff[ctl.lane] + 48'(w_ff);
         end
         wgba_pkg::OP_EVAL: begin
            valid_ff    <= valid_now;
            ovalid_ff   <= valid_now;
            mean_az_ff  <= '0;
            mean_ff[0]  <= '0;
            mean_ff[1]  <= '0;
            mean_ff[2]  <= '0;
            sigma_ff[0] <= '0;
            sigma_ff[1] <= '0;
            sigma_ff[2] <= '0;
         end
         wgba_pkg::OP_AZDIV: begin
            sign_ff <= azs_ff[31];
         end
         wgba_pkg::OP_AZTAKE: begin
            mean_az_ff <= sign_ff ? az_neg[11:0] : div_quo[11:0];
         end
         wgba_pkg::OP_MDIV: begin
            sign_ff <= ws_ff[ctl.lane][63];
         end
         wgba_pkg::OP_MTAKE: begin
            mean_ff[ctl.lane] <= mean_sat;
         end
         wgba_pkg::OP_STAKE: begin
            sigma_ff[ctl.lane] <= sqrt_root[16] ? 16'hFFFF : sqrt_root[15:0];
         end
         default: begin
         end
      endcase
   end

   assign sts.div_done  = div_done;
   assign sts.sqrt_done = sqrt_done;
   assign sts.full      = (cnt_ff == 16'hFFFF);
   assign sts.valid     = valid_ff;

   assign rsp_strobe         = strobe_ff;
   assign rsp_out_bin        = bin_ff;
   assign rsp_valid_res      = ovalid_ff;
   assign rsp_mean_azimuth   = mean_az_ff;
   assign rsp_mean_velocity  = mean_ff[0];
   assign rsp_velocity_sigma = sigma_ff[0];
   assign rsp_mean_power     = mean_ff[1];
   assign rsp_power_sigma    = sigma_ff[1];
   assign rsp_mean_width     = mean_ff[2];
   assign rsp_width_sigma    = sigma_ff[2];
   assign rsp_sample_count   = cnt_ff;

endmodule

// ===== rtl/core/wgba_ctrl.sv =====
module wgba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_kind,
   input  wgba_pkg::sts_type sts,
   output wgba_pkg::ctl_type ctl,
   output logic              busy
);

   localparam logic [4:0] ST_CLEAR  = 5'd0;
   localparam logic [4:0] ST_IDLE   = 5'd1;
   localparam logic [4:0] ST_READ   = 5'd2;
   localparam logic [4:0] ST_LATCH  = 5'd3;
   localparam logic [4:0] ST_SCHK   = 5'd4;
   localparam logic [4:0] ST_WDIV   = 5'd5;
   localparam logic [4:0] ST_WWAIT  = 5'd6;
   localparam logic [4:0] ST_MUL    = 5'd7;
   localparam logic [4:0] ST_ACC    = 5'd8;
   localparam logic [4:0] ST_WRITE  = 5'd9;
   localparam logic [4:0] ST_EVAL   = 5'd10;
   localparam logic [4:0] ST_VCHK   = 5'd11;
   localparam logic [4:0] ST_AZDIV  = 5'd12;
   localparam logic [4:0] ST_AZWAIT = 5'd13;
   localparam logic [4:0] ST_MDIV   = 5'd14;
   localparam logic [4:0] ST_MWAIT  = 5'd15;
   localparam logic [4:0] ST_SDIV   = 5'd16;
   localparam logic [4:0] ST_SWAIT  = 5'd17;
   localparam logic [4:0] ST_QWAIT  = 5'd18;
   localparam logic [4:0] ST_FIRE   = 5'd19;

   logic [4:0] state_ff, state_in;
   logic [1:0] lane_ff, lane_in;
   logic [1:0] kind_ff, kind_in;
   logic [wgba_pkg::BIN_W-1:0] addr_ff, addr_in;

   always_comb begin
      state_in = state_ff;
      lane_in  = lane_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      ctl.op   = wgba_pkg::OP_NONE;
      ctl.lane = lane_ff;
      ctl.addr = addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctl.op  = wgba_pkg::OP_CLEAR;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == wgba_pkg::BIN_W'(wgba_pkg::BIN_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && !reset) begin
               ctl.op  = wgba_pkg::OP_LOAD;
               kind_in = req_kind;
               case (req_kind)
                  wgba_pkg::KIND_SAMPLE, wgba_pkg::KIND_READ: state_in = ST_READ;
                  wgba_pkg::KIND_NEWP: begin
                     state_in = ST_CLEAR;
                     addr_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            ctl.op   = wgba_pkg::OP_READ;
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            ctl.op   = wgba_pkg::OP_LATCH;
            lane_in  = 2'd0;
            state_in = (kind_ff == wgba_pkg::KIND_READ) ? ST_EVAL : ST_SCHK;
         end
         ST_SCHK: begin
            // a full bin takes no more samples
            state_in = sts.full ? ST_IDLE : ST_WDIV;
         end
         ST_WDIV: begin
            ctl.op   = wgba_pkg::OP_WDIV;
            state_in = ST_WWAIT;
         end
         ST_WWAIT: begin
            if (sts.div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            ctl.op   = wgba_pkg::OP_MUL;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            ctl.op = wgba_pkg::OP_ACC;
            if (lane_ff == 2'd2) begin
               state_in = ST_WRITE;
            end else begin
               lane_in  = lane_ff + 1'b1;
               state_in = ST_WDIV;
            end
         end
         ST_WRITE: begin
            ctl.op   = wgba_pkg::OP_WRITE;
            state_in = ST_IDLE;
         end
         ST_EVAL: begin
            ctl.op   = wgba_pkg::OP_EVAL;
            state_in = ST_VCHK;
         end
         ST_VCHK: begin
            state_in = sts.valid ? ST_AZDIV : ST_FIRE;
         end
         ST_AZDIV: begin
            ctl.op   = wgba_pkg::OP_AZDIV;
            state_in = ST_AZWAIT;
         end
         ST_AZWAIT: begin
            if (sts.div_done) begin
               ctl.op   = wgba_pkg::OP_AZTAKE;
               state_in = ST_MDIV;
            end
         end
         ST_MDIV: begin
            ctl.op   = wgba_pkg::OP_MDIV;
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (sts.div_done) begin
               ctl.op   = wgba_pkg::OP_MTAKE;
               state_in = ST_SDIV;
            end
         end
         ST_SDIV: begin
            ctl.op   = wgba_pkg::OP_SDIV;
            state_in = ST_SWAIT;
         end
         ST_SWAIT: begin
            if (sts.div_done) begin
               ctl.op   = wgba_pkg::OP_SQRT;
               state_in = ST_QWAIT;
            end
         end
         ST_QWAIT: begin
            if (sts.sqrt_done) begin
               ctl.op = wgba_pkg::OP_STAKE;
               if (lane_ff == 2'd2) begin
                  state_in = ST_FIRE;
               end else begin
                  lane_in  = lane_ff + 1'b1;
                  state_in = ST_MDIV;
               end
            end
         end
         ST_FIRE: begin
            ctl.op   = wgba_pkg::OP_FIRE;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         lane_ff  <= '0;
         kind_ff  <= '0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
         kind_ff  <= kind_in;
         addr_ff  <= addr_in;
      end
   end

   assign busy = reset || (state_ff != ST_IDLE);

endmodule

// ===== rtl/core/weighted_grid_bin_accumulator_top.sv =====
// Channel   | Handshake               | Payload
// request   | start, busy             | req_kind .. req_pixel_count
// response  | rsp_strobe (one cycle)  | rsp_out_bin .. rsp_sample_count
// csr       | csr_we                  | csr_index, csr_wdata
//
// Scan: taken in the idle state. Sample: three 33-step weight divisions in the
// shared divider, none for a full bin. Read of an invalid bin: no divisions; of a
// valid bin the azimuth and three mean divisions, three 33-step divisions and
// three 17-step square roots, one shared divider and root unit.
// Reset and new period clear the bin memory at one row per cycle while busy.
// The response is never stalled; it is shown for one cycle.
module weighted_grid_bin_accumulator_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_kind,
   input  logic [wgba_pkg::BIN_W-1:0] req_bin,
   input  logic signed [15:0]         req_velocity,
   input  logic [15:0]                req_velocity_error,
   input  logic signed [15:0]         req_power,
   input  logic [15:0]                req_power_error,
   input  logic signed [15:0]         req_width,
   input  logic [15:0]                req_width_error,
   input  logic signed [11:0]         req_azimuth,
   input  logic [10:0]                req_pixel_count,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [15:0]                csr_wdata,
   output logic                       rsp_strobe,
   output logic [wgba_pkg::BIN_W-1:0] rsp_out_bin,
   output logic                       rsp_valid_res,
   output logic signed [11:0]         rsp_mean_azimuth,
   output logic signed [15:0]         rsp_mean_velocity,
   output logic [15:0]                rsp_velocity_sigma,
   output logic signed [15:0]         rsp_mean_power,
   output logic [15:0]                rsp_power_sigma,
   output logic signed [15:0]         rsp_mean_width,
   output logic [15:0]                rsp_width_sigma,
   output logic [15:0]                rsp_sample_count
);

   wgba_pkg::ctl_type ctl;
   wgba_pkg::sts_type sts;

   wgba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .sts      (sts),
      .ctl      (ctl),
      .busy     (busy)
   );

   wgba_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_kind           (req_kind),
      .req_bin            (req_bin),
      .req_velocity       (req_velocity),
      .req_velocity_error (req_velocity_error),
      .req_power          (req_power),
      .req_power_error    (req_power_error),
      .req_width          (req_width),
      .req_width_error    (req_width_error),
      .req_azimuth        (req_azimuth),
      .req_pixel_count    (req_pixel_count),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_strobe         (rsp_strobe),
      .rsp_out_bin        (rsp_out_bin),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_mean_azimuth   (rsp_mean_azimuth),
      .rsp_mean_velocity  (rsp_mean_velocity),
      .rsp_velocity_sigma (rsp_velocity_sigma),
      .rsp_mean_power     (rsp_mean_power),
      .rsp_power_sigma    (rsp_power_sigma),
      .rsp_mean_width     (rsp_mean_width),
      .rsp_width_sigma    (rsp_width_sigma),
      .rsp_sample_count   (rsp_sample_count)
   );

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   a_read_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == wgba_pkg::KIND_READ) |=> busy)
      else $error("read request did not start work");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |->
         (rsp_mean_velocity == 16'd0 && rsp_velocity_sigma == 16'd0 &&
          rsp_mean_azimuth == 12'd0))
      else $error("invalid bin reported nonzero statistics");

   a_strobe_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a request in progress");

endmodule

// ===== sim/tb_weighted_grid_bin_accumulator_top.sv =====
`timescale 1ns / 100ps

module tb_weighted_grid_bin_accumulator_top;

   localparam int CYCLE_LIMIT = 6000000;

   typedef struct {
      logic [1:0]         kind;
      logic [11:0]        bin;
      logic signed [15:0] velocity;
      logic [15:0]        velocity_error;
      logic signed [15:0] power;
      logic [15:0]        power_error;
      logic signed [15:0] width;
      logic [15:0]        width_error;
      logic signed [11:0] azimuth;
      logic [10:0]        pixel_count;
   } request_type;

   typedef struct {
      logic [11:0] out_bin;
      logic        valid_res;
      logic [11:0] mean_azimuth;
      logic [15:0] mean_velocity;
      logic [15:0] velocity_sigma;
      logic [15:0] mean_power;
      logic [15:0] power_sigma;
      logic [15:0] mean_width;
      logic [15:0] width_sigma;
      logic [15:0] sample_count;
   } bin_report_type;

   logic clock, reset, start, busy;
   logic [1:0] req_kind;
   logic [wgba_pkg::BIN_W-1:0] req_bin;
   logic signed [15:0] req_velocity, req_power, req_width;
   logic [15:0] req_velocity_error, req_power_error, req_width_error;
   logic signed [11:0] req_azimuth;
   logic [10:0] req_pixel_count;
   logic csr_we;
   logic [1:0] csr_index;
   logic [15:0] csr_wdata;
   logic rsp_strobe, rsp_valid_res;
   logic [wgba_pkg::BIN_W-1:0] rsp_out_bin;
   logic signed [11:0] rsp_mean_azimuth;
   logic signed [15:0] rsp_mean_velocity, rsp_mean_power, rsp_mean_width;
   logic [15:0] rsp_velocity_sigma, rsp_power_sigma, rsp_width_sigma, rsp_sample_count;

   weighted_grid_bin_accumulator_top dut (.*);

   // predictor state
   logic [15:0]        bin_cnt   [wgba_pkg::BIN_COUNT];
   logic signed [31:0] az_acc    [wgba_pkg::BIN_COUNT];
   longint             vel_acc   [wgba_pkg::BIN_COUNT];
   longint             pwr_acc   [wgba_pkg::BIN_COUNT];
   longint             wid_acc   [wgba_pkg::BIN_COUNT];
   logic [63:0]        vel_wacc  [wgba_pkg::BIN_COUNT];
   logic [63:0]        pwr_wacc  [wgba_pkg::BIN_COUNT];
   logic [63:0]        wid_wacc  [wgba_pkg::BIN_COUNT];
   logic [15:0]        scans;
   logic [15:0]        vel_floor, pwr_floor, wid_floor;

   request_type    pending_requests[$];
   bin_report_type expected_reports[$];
   request_type    cur;
   logic           presenting, calm;
   int             gap, mismatches, cycles;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] weight_for(logic [15:0] e, logic [15:0] fl);
      logic [63:0] x;
      x = 64'(e);
      if (x < 64'(fl)) x = 64'(fl);
      if (x == 64'd0) x = 64'd1;
      return 64'h1_0000_0000 / (x * x);
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] x, r, b;
      x = v; r = 0; b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] sigma_for(logic [63:0] w);
      logic [63:0] s;
      if (w == 0) return 16'd0;
      s = root_floor(64'h1_0000_0000 / w);
      return (s > 65535) ? 16'hFFFF : s[15:0];
   endfunction

   function automatic logic [15:0] mean_for(longint sum, logic [63:0] w);
      longint q;
      if (w == 0) return 16'd0;
      q = sum / longint'(w);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic void clear_bin(int b);
      bin_cnt[b] = 0; az_acc[b] = 0;
      vel_acc[b] = 0; pwr_acc[b] = 0; wid_acc[b] = 0;
      vel_wacc[b] = 0; pwr_wacc[b] = 0; wid_wacc[b] = 0;
   endfunction

   function automatic void clear_grid();
      for (int b = 0; b < wgba_pkg::BIN_COUNT; b++) clear_bin(b);
      scans = 0;
   endfunction

   function automatic void accumulate(request_type r);
      bin_report_type rep;
      logic [63:0] wv, wp, ww, cnt;
      logic signed [31:0] az;
      int b;
      b = r.bin;
      case (r.kind)
         wgba_pkg::KIND_SAMPLE: begin
            if (bin_cnt[b] != 16'hFFFF) begin
               wv = weight_for(r.velocity_error, vel_floor);
               wp = weight_for(r.power_error, pwr_floor);
               ww = weight_for(r.width_error, wid_floor);
               az_acc[b] += 32'(r.azimuth);
               vel_acc[b] += -longint'(r.velocity) * longint'(wv);
               pwr_acc[b] += longint'(r.power) * longint'(wp);
               wid_acc[b] += longint'(r.width) * longint'(ww);
               vel_wacc[b] += wv; pwr_wacc[b] += wp; wid_wacc[b] += ww;
               bin_cnt[b]++;
            end
         end
         wgba_pkg::KIND_SCAN: if (scans != 16'hFFFF) scans++;
         wgba_pkg::KIND_NEWP: clear_grid();
         default: begin
            rep = '{default: '0};
            rep.out_bin = r.bin;
            cnt = 64'(bin_cnt[b]);
            rep.sample_count = bin_cnt[b];
            if (cnt != 0 && 4 * cnt > 64'(scans) * 64'(r.pixel_count)) begin
               rep.valid_res = 1'b1;
               az = az_acc[b] / $signed({16'd0, bin_cnt[b]});
               rep.mean_azimuth = az[11:0];
               rep.mean_velocity = mean_for(vel_acc[b], vel_wacc[b]);
               rep.velocity_sigma = sigma_for(vel_wacc[b]);
               rep.mean_power = mean_for(pwr_acc[b], pwr_wacc[b]);
               rep.power_sigma = sigma_for(pwr_wacc[b]);
               rep.mean_width = mean_for(wid_acc[b], wid_wacc[b]);
               rep.width_sigma = sigma_for(wid_wacc[b]);
            end
            clear_bin(b);
            expected_reports.push_back(rep);
         end
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         presenting = 0;
         gap = 0;
      end else begin
         if (start && !busy) begin
            accumulate(cur);
            presenting = 0;
            if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
         end else if (gap > 0) begin
            gap--;
         end
         if (!presenting && gap == 0 && pending_requests.size() > 0) begin
            cur = pending_requests.pop_front();
            presenting = 1;
            req_kind <= cur.kind;
            req_bin <= cur.bin;
            req_velocity <= cur.velocity;
            req_velocity_error <= cur.velocity_error;
            req_power <= cur.power;
            req_power_error <= cur.power_error;
            req_width <= cur.width;
            req_width_error <= cur.width_error;
            req_azimuth <= cur.azimuth;
            req_pixel_count <= cur.pixel_count;
         end
         start <= presenting;
      end
   end

   // response monitor
   always @(posedge clock) begin
      bin_report_type e;
      cycles++;
      if (!reset && rsp_strobe) begin
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response for bin %0d", rsp_out_bin);
         end else begin
            e = expected_reports.pop_front();
            if (rsp_out_bin !== e.out_bin || rsp_valid_res !== e.valid_res ||
                rsp_mean_azimuth !== e.mean_azimuth ||
                rsp_mean_velocity !== e.mean_velocity ||
                rsp_velocity_sigma !== e.velocity_sigma ||
                rsp_mean_power !== e.mean_power || rsp_power_sigma !== e.power_sigma ||
                rsp_mean_width !== e.mean_width || rsp_width_sigma !== e.width_sigma ||
                rsp_sample_count !== e.sample_count) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch bin %0d exp v%0d az%0d mv%0d vs%0d mp%0d ps%0d",
                           e.out_bin, e.valid_res, e.mean_azimuth, e.mean_velocity,
                           e.velocity_sigma, e.mean_power, e.power_sigma);
                  $display("   exp mw%0d ws%0d n%0d",
                           e.mean_width, e.width_sigma, e.sample_count);
                  $display("   got bin %0d v%0d az%0d mv%0d vs%0d mp%0d ps%0d",
                           rsp_out_bin, rsp_valid_res, rsp_mean_azimuth, rsp_mean_velocity,
                           rsp_velocity_sigma, rsp_mean_power, rsp_power_sigma);
                  $display("   got mw%0d ws%0d n%0d",
                           rsp_mean_width, rsp_width_sigma, rsp_sample_count);
               end
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic request_type make_req(logic [1:0] k, logic [11:0] b);
      request_type r;
      r.kind = k; r.bin = b;
      r.velocity = 16'($urandom); r.power = 16'($urandom); r.width = 16'($urandom);
      if ($urandom_range(0, 2) == 0) begin
         r.velocity_error = 16'($urandom);
         r.power_error = 16'($urandom);
         r.width_error = 16'($urandom);
      end else begin
         r.velocity_error = 16'($urandom_range(0, 300));
         r.power_error = 16'($urandom_range(0, 300));
         r.width_error = 16'($urandom_range(0, 300));
      end
      r.azimuth = $signed(12'($urandom_range(0, 3600))) - 12'sd1800;
      r.pixel_count = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 1024))
                                                 : 11'($urandom_range(0, 3));
      return r;
   endfunction

   function automatic request_type full_req(logic [1:0] k, logic [11:0] b,
                                            logic signed [15:0] v, logic [15:0] e,
                                            logic signed [11:0] az, logic [10:0] px);
      request_type r;
      r = '{kind: k, bin: b, velocity: v, velocity_error: e, power: v, power_error: e,
            width: v, width_error: e, azimuth: az, pixel_count: px};
      return r;
   endfunction

   task automatic random_phase(int n);
      int roll;
      logic [11:0] b;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 999);
         b = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
         if (roll < 600) pending_requests.push_back(make_req(wgba_pkg::KIND_SAMPLE, b));
         else if (roll < 860) pending_requests.push_back(make_req(wgba_pkg::KIND_READ, b));
         else if (roll < 997) pending_requests.push_back(make_req(wgba_pkg::KIND_SCAN, b));
         else pending_requests.push_back(make_req(wgba_pkg::KIND_NEWP, b));
      end
   endtask

   task automatic push_idle(logic [1:0] k);
      pending_requests.push_back(full_req(k, 12'd0, 16'sd0, 16'd0, 12'sd0, 11'd0));
   endtask

   // waits until the block is quiet; new period has no response, so also wait on busy
   task automatic drain();
      while (pending_requests.size() > 0 || presenting || start ||
             expected_reports.size() > 0)
         @(posedge clock);
      repeat (500) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_floors(logic [15:0] v, logic [15:0] p, logic [15:0] w);
      logic [15:0] vals[3];
      vals = '{v, p, w};
      for (int i = 0; i < 3; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= (i == 0) ? wgba_pkg::CSR_VEL_FLOOR :
                      (i == 1) ? wgba_pkg::CSR_PWR_FLOOR : wgba_pkg::CSR_WID_FLOOR;
         csr_wdata <= vals[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      vel_floor = v; pwr_floor = p; wid_floor = w;
   endtask

   initial begin
      reset = 1; start = 0; csr_we = 0; csr_index = wgba_pkg::CSR_VEL_FLOOR; csr_wdata = 0;
      req_kind = wgba_pkg::KIND_SAMPLE; req_bin = 0; req_velocity = 0;
      req_velocity_error = 0; req_power = 0; req_power_error = 0; req_width = 0;
      req_width_error = 0; req_azimuth = 0; req_pixel_count = 0;
      calm = 0; mismatches = 0; cycles = 0;
      clear_grid();
      vel_floor = wgba_pkg::VEL_FLOOR_RST;
      pwr_floor = wgba_pkg::PWR_FLOOR_RST;
      wid_floor = wgba_pkg::WID_FLOOR_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // extremes and special cases
      pending_requests.push_back(full_req(wgba_pkg::KIND_SAMPLE, 12'd5, 16'sh8000, 16'd0,
                                          -12'sd1800, 11'd0));
      pending_requests.push_back(full_req(wgba_pkg::KIND_SAMPLE, 12'd5, 16'sd32767, 16'hFFFF,
                                          12'sd1800, 11'd0));
      pending_requests.push_back(full_req(wgba_pkg::KIND_SAMPLE, 12'd4095, 16'sd32767, 16'd1,
                                          12'sd1800, 11'd0));
      push_idle(wgba_pkg::KIND_SCAN);
      pending_requests.push_back(full_req(wgba_pkg::KIND_READ, 12'd5, 16'sd0, 16'd0,
                                          12'sd0, 11'd0));
      pending_requests.push_back(full_req(wgba_pkg::KIND_READ, 12'd5, 16'sd0, 16'd0,
                                          12'sd0, 11'd0));
      pending_requests.push_back(full_req(wgba_pkg::KIND_READ, 12'd4095, 16'sd0, 16'd0,
                                          12'sd0, 11'd1024));
      pending_requests.push_back(full_req(wgba_pkg::KIND_SAMPLE, 12'd7, -16'sd1, 16'd3,
                                          -12'sd1, 11'd0));
      push_idle(wgba_pkg::KIND_SCAN);
      pending_requests.push_back(full_req(wgba_pkg::KIND_READ, 12'd7, 16'sd0, 16'd0,
                                          12'sd0, 11'd1024));
      pending_requests.push_back(full_req(wgba_pkg::KIND_SAMPLE, 12'd0, 16'sd1234, 16'd50,
                                          12'sd7, 11'd0));
      push_idle(wgba_pkg::KIND_NEWP);
      push_idle(wgba_pkg::KIND_READ);
      drain();

      write_floors(16'd0, 16'd0, 16'd0);
      pending_requests.push_back(full_req(wgba_pkg::KIND_SAMPLE, 12'd9, 16'sd300, 16'd0,
                                          12'sd0, 11'd0));
      pending_requests.push_back(full_req(wgba_pkg::KIND_READ, 12'd9, 16'sd0, 16'd0,
                                          12'sd0, 11'd0));
      random_phase(450);
      drain();

      write_floors(16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(450);
      drain();

      write_floors(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 400)),
                   16'($urandom_range(1, 65535)));
      random_phase(450);
      drain();

      // many scans against a fresh period, then the threshold on both sides
      push_idle(wgba_pkg::KIND_NEWP);
      for (int i = 0; i < 40; i++) push_idle(wgba_pkg::KIND_SCAN);
      pending_requests.push_back(full_req(wgba_pkg::KIND_SAMPLE, 12'd3, 16'sd10, 16'd2,
                                          12'sd5, 11'd0));
      pending_requests.push_back(full_req(wgba_pkg::KIND_SAMPLE, 12'd4, 16'sd10, 16'd2,
                                          12'sd5, 11'd0));
      pending_requests.push_back(full_req(wgba_pkg::KIND_READ, 12'd3, 16'sd0, 16'd0,
                                          12'sd0, 11'd1));
      pending_requests.push_back(full_req(wgba_pkg::KIND_READ, 12'd4, 16'sd0, 16'd0,
                                          12'sd0, 11'd0));
      push_idle(wgba_pkg::KIND_NEWP);
      drain();

      write_floors(wgba_pkg::VEL_FLOOR_RST, wgba_pkg::PWR_FLOOR_RST, wgba_pkg::WID_FLOOR_RST);
      calm = 1;
      random_phase(550);
      drain();

      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
